### rtl/core/gpbc_pkg.sv
// Shared constants, codes, types and functions of the GPIO pin blink controller.
package gpbc_pkg;

  localparam int unsigned TABLE_LEN    = 8;
  localparam int unsigned NUM_PINS_DEF = 8;
  localparam int unsigned PERIOD_W     = 10;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned DIV_STEPS    = 10;
  localparam logic [PERIOD_W-1:0] MS_PER_S    = 10'd1000;
  localparam logic [15:0]         MAX_BLINK_HZ = 16'd1000;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_DIR   = 3'd1;
  localparam logic [2:0] MODE_LEVEL = 3'd2;
  localparam logic [2:0] MODE_BLINK = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_WRONG_DIR = 2'd2;
  localparam logic [1:0] ST_BAD_VALUE = 2'd3;

  localparam logic [7:0] PIN_TABLE [TABLE_LEN] = '{
    8'd21, 8'd19, 8'd18, 8'd5, 8'd17, 8'd16, 8'd4, 8'd2
  };

  typedef struct packed {
    logic load;
    logic tick_start;
    logic tick_step;
    logic div_start;
    logic div_step;
    logic commit;
  } gpbc_ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic div_ok;
    logic cnt_last;
    logic out_free;
  } gpbc_stat_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } gpbc_entry_t;

  // Looks a physical pin up among the first n table entries.
  function automatic gpbc_entry_t find_entry(logic [7:0] pin, int unsigned n);
    gpbc_entry_t e;
    e = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i < n && PIN_TABLE[i] == pin) begin
        e.found = 1'b1;
        e.idx   = 3'(i);
      end
    end
    return e;
  endfunction

endpackage

### rtl/core/gpbc_cmd_if.sv
// Command channel interface carrying one command beat.
interface gpbc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  pin_number;
  logic [15:0] value;
  logic [7:0]  sampled_levels;

  modport source (output valid, mode, pin_number, value, sampled_levels, input ready);
  modport sink   (input valid, mode, pin_number, value, sampled_levels, output ready);
endinterface

### rtl/core/gpbc_rsp_if.sv
// Response channel interface carrying one result beat.
interface gpbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       read_level;
  logic [7:0] driven_levels;
  logic [7:0] output_enables;

  modport source (output valid, status, read_level, driven_levels, output_enables,
                  input ready);
  modport sink   (input valid, status, read_level, driven_levels, output_enables,
                  output ready);
endinterface

### rtl/core/gpbc_ctrl.sv
// Controller state machine that sequences decode, tick scan, division and response.
module gpbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  gpbc_pkg::gpbc_stat_t stat,
  output gpbc_pkg::gpbc_ctrl_t ctrl
);

  typedef enum logic [2:0] {IDLE, DECODE, TICK, DIV, RESP} state_t;

  state_t state;
  state_t state_next;

  assign cmd_ready = (state == IDLE);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (cmd_valid) begin
          ctrl.load  = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        priority if (stat.is_tick) begin
          ctrl.tick_start = 1'b1;
          state_next      = TICK;
        end else if (stat.div_ok) begin
          ctrl.div_start = 1'b1;
          state_next     = DIV;
        end else begin
          state_next = RESP;
        end
      end
      TICK: begin
        ctrl.tick_step = 1'b1;
        if (stat.cnt_last) state_next = RESP;
      end
      DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.cnt_last) state_next = RESP;
      end
      RESP: begin
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/gpbc_datapath.sv
// Datapath with pin state, tick scan, period divider and response register.
module gpbc_datapath #(
  parameter int unsigned NUM_PINS = gpbc_pkg::NUM_PINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  gpbc_cmd_if.sink             cmd,
  gpbc_rsp_if.source           rsp,
  input  gpbc_pkg::gpbc_ctrl_t ctrl,
  output gpbc_pkg::gpbc_stat_t stat
);

  localparam int unsigned IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [7:0] PIN_MASK = 8'((16'd1 << NUM_PINS) - 16'd1);

  logic [2:0]  c_mode;
  logic [7:0]  c_pin;
  logic [15:0] c_value;
  logic [7:0]  c_sampled;

  logic [7:0] dir;
  logic [7:0] blink;
  logic [7:0] level;
  logic [gpbc_pkg::PERIOD_W-1:0] period [NUM_PINS];
  logic [gpbc_pkg::TIME_W-1:0]   last_t [NUM_PINS];
  logic [gpbc_pkg::TIME_W-1:0]   time_now;

  logic [gpbc_pkg::CNT_W-1:0]    cnt;
  logic [gpbc_pkg::PERIOD_W:0]   rem;
  logic [gpbc_pkg::PERIOD_W-1:0] dvd;
  logic [gpbc_pkg::PERIOD_W-1:0] quo;

  logic       out_valid;
  logic [1:0] out_status;
  logic       out_rd;
  logic [7:0] out_driven;
  logic [7:0] out_oe;

  gpbc_pkg::gpbc_entry_t entry;
  logic [1:0] status;
  logic       rd;
  logic       dir_bit;
  logic [7:0] dir_next;
  logic [7:0] blink_next;
  logic [7:0] level_next;
  logic [IDX_W-1:0] scan_idx;
  logic [gpbc_pkg::TIME_W-1:0] elapsed;
  logic       toggle;
  logic [gpbc_pkg::PERIOD_W:0] rem_sh;
  logic       ge;

  assign entry   = gpbc_pkg::find_entry(c_pin, NUM_PINS);
  assign dir_bit = dir[entry.idx];

  always_comb begin
    status = gpbc_pkg::ST_OK;
    rd     = 1'b0;
    unique case (c_mode)
      gpbc_pkg::MODE_TICK: status = gpbc_pkg::ST_OK;
      gpbc_pkg::MODE_DIR: begin
        priority if (c_value > 16'd1) status = gpbc_pkg::ST_BAD_VALUE;
        else if (!entry.found)        status = gpbc_pkg::ST_UNKNOWN;
        else                          status = gpbc_pkg::ST_OK;
      end
      gpbc_pkg::MODE_LEVEL: begin
        priority if (!entry.found)    status = gpbc_pkg::ST_UNKNOWN;
        else if (!dir_bit)            status = gpbc_pkg::ST_WRONG_DIR;
        else if (c_value > 16'd1)     status = gpbc_pkg::ST_BAD_VALUE;
        else                          status = gpbc_pkg::ST_OK;
      end
      gpbc_pkg::MODE_BLINK: begin
        priority if (!entry.found)    status = gpbc_pkg::ST_UNKNOWN;
        else if (!dir_bit)            status = gpbc_pkg::ST_WRONG_DIR;
        else if (c_value == 16'd0 || c_value > gpbc_pkg::MAX_BLINK_HZ)
                                      status = gpbc_pkg::ST_BAD_VALUE;
        else                          status = gpbc_pkg::ST_OK;
      end
      gpbc_pkg::MODE_READ: begin
        priority if (!entry.found)    status = gpbc_pkg::ST_UNKNOWN;
        else if (dir_bit)             status = gpbc_pkg::ST_WRONG_DIR;
        else begin
          status = gpbc_pkg::ST_OK;
          rd     = c_sampled[entry.idx];
        end
      end
      default: status = gpbc_pkg::ST_BAD_VALUE;
    endcase
  end

  always_comb begin
    dir_next   = dir;
    blink_next = blink;
    level_next = level;
    if (status == gpbc_pkg::ST_OK) begin
      unique case (c_mode)
        gpbc_pkg::MODE_DIR:   dir_next[entry.idx] = c_value[0];
        gpbc_pkg::MODE_LEVEL: begin
          blink_next[entry.idx] = 1'b0;
          level_next[entry.idx] = c_value[0];
        end
        gpbc_pkg::MODE_BLINK: blink_next[entry.idx] = 1'b1;
        default: dir_next = dir;
      endcase
    end
  end

  assign scan_idx = cnt[IDX_W-1:0];
  assign elapsed  = time_now - last_t[scan_idx];
  assign toggle   = dir[scan_idx] && blink[scan_idx] &&
                    (elapsed > {{(gpbc_pkg::TIME_W-gpbc_pkg::PERIOD_W){1'b0}}, period[scan_idx]});

  assign rem_sh = {rem[gpbc_pkg::PERIOD_W-1:0], dvd[gpbc_pkg::PERIOD_W-1]};
  assign ge     = rem_sh >= {1'b0, c_value[gpbc_pkg::PERIOD_W-1:0]};

  assign stat.is_tick  = (c_mode == gpbc_pkg::MODE_TICK);
  assign stat.div_ok   = (c_mode == gpbc_pkg::MODE_BLINK) && (status == gpbc_pkg::ST_OK);
  assign stat.cnt_last = stat.is_tick ? (cnt == gpbc_pkg::CNT_W'(NUM_PINS - 1))
                                      : (cnt == gpbc_pkg::CNT_W'(gpbc_pkg::DIV_STEPS - 1));
  assign stat.out_free = !out_valid || rsp.ready;

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_level     = out_rd;
  assign rsp.driven_levels  = out_driven;
  assign rsp.output_enables = out_oe;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c_mode    <= cmd.mode;
      c_pin     <= cmd.pin_number;
      c_value   <= cmd.value;
      c_sampled <= cmd.sampled_levels;
    end
    if (ctrl.tick_start || ctrl.div_start) begin
      cnt <= '0;
    end else if (ctrl.tick_step || ctrl.div_step) begin
      cnt <= cnt + gpbc_pkg::CNT_W'(1);
    end
    if (ctrl.div_start) begin
      rem <= '0;
      dvd <= gpbc_pkg::MS_PER_S;
      quo <= '0;
    end else if (ctrl.div_step) begin
      rem <= ge ? (rem_sh - {1'b0, c_value[gpbc_pkg::PERIOD_W-1:0]}) : rem_sh;
      dvd <= {dvd[gpbc_pkg::PERIOD_W-2:0], 1'b0};
      quo <= {quo[gpbc_pkg::PERIOD_W-2:0], ge};
    end
    if (ctrl.commit) begin
      out_status <= status;
      out_rd     <= rd;
      out_driven <= level_next & dir_next & PIN_MASK;
      out_oe     <= dir_next & PIN_MASK;
    end
    if (rst) begin
      dir       <= PIN_MASK;
      blink     <= '0;
      level     <= '0;
      time_now  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_PINS; i++) begin
        period[i] <= '0;
        last_t[i] <= '0;
      end
    end else begin
      if (ctrl.tick_start) begin
        time_now <= time_now + gpbc_pkg::TIME_W'(1);
      end
      if (ctrl.tick_step && toggle) begin
        level[scan_idx]  <= ~level[scan_idx];
        last_t[scan_idx] <= time_now;
      end
      if (ctrl.commit) begin
        dir   <= dir_next;
        blink <= blink_next;
        level <= level_next;
        if (stat.div_ok) begin
          period[entry.idx[IDX_W-1:0]] <= quo;
        end
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/gpio_pin_blink_controller.sv
// Top level of the GPIO pin blink controller joining controller and datapath.
//
// Commands arrive as beats on the cmd channel and each produces exactly one
// result beat on the rsp channel, in order. A command is taken only while the
// block is idle, so one command is in flight at a time.
// A tick scans the pins one per cycle with a single shared elapsed-time
// compare before its result is valid. A blink frequency command that passes
// its checks runs the ten-step restoring divider that forms the period. Every
// other command goes from decode straight to the response.
// The result sits in an output register; the block accepts the next command
// while it waits, and a new result is loaded only once the old beat is taken.
// While the receiver stalls, the block holds at most one finished command
// ready to commit and stops accepting beyond that.
// Synchronous reset makes every pin an output, driven low in latch mode, with
// zero periods, zero toggle times and the millisecond clock at zero.
module gpio_pin_blink_controller #(
  parameter int unsigned NUM_PINS = gpbc_pkg::NUM_PINS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gpbc_cmd_if.sink   cmd,
  gpbc_rsp_if.source rsp
);

  gpbc_pkg::gpbc_ctrl_t ctrl;
  gpbc_pkg::gpbc_stat_t stat;
  logic                 ready;

  assign cmd.ready = ready;

  gpbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  gpbc_datapath #(
    .NUM_PINS (NUM_PINS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .rsp  (rsp),
    .ctrl (ctrl),
    .stat (stat)
  );

endmodule

### tb/tb.sv
// Testbench for the GPIO pin blink controller: command and response traffic with checking.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_PINS    = gpbc_pkg::NUM_PINS_DEF;
  localparam int          RANDOM_CMDS = 900;
  localparam int          HOLD_AT     = 300;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_AT    = 600;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          TAIL_CYCLES = 30;

  localparam logic [2:0]  MODE_SPARE0 = 3'd5;
  localparam logic [2:0]  MODE_SPARE1 = 3'd6;
  localparam logic [2:0]  MODE_SPARE2 = 3'd7;
  localparam logic [15:0] VAL_LOW     = 16'd0;
  localparam logic [15:0] VAL_HIGH    = 16'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  pin;
    logic [15:0] value;
    logic [7:0]  sampled;
  } pin_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       rd;
    logic [7:0] driven;
    logic [7:0] oe;
  } pin_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gpbc_cmd_if cmd_ch ();
  gpbc_rsp_if rsp_ch ();

  logic        cmd_valid   = 1'b0;
  logic [2:0]  cmd_mode    = gpbc_pkg::MODE_TICK;
  logic [7:0]  cmd_pin     = 8'h00;
  logic [15:0] cmd_value   = 16'h0000;
  logic [7:0]  cmd_sampled = 8'h00;
  logic        rsp_ready   = 1'b0;

  assign cmd_ch.valid          = cmd_valid;
  assign cmd_ch.mode           = cmd_mode;
  assign cmd_ch.pin_number     = cmd_pin;
  assign cmd_ch.value          = cmd_value;
  assign cmd_ch.sampled_levels = cmd_sampled;
  assign rsp_ch.ready          = rsp_ready;

  gpio_pin_blink_controller DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  // Predicted pin state.
  logic [7:0]                    dir_bits;
  logic [7:0]                    blink_bits;
  logic [7:0]                    level_bits;
  logic [gpbc_pkg::PERIOD_W-1:0] period_ms [NUM_PINS];
  logic [gpbc_pkg::TIME_W-1:0]   toggle_ms [NUM_PINS];
  logic [gpbc_pkg::TIME_W-1:0]   clock_ms;

  pin_cmd_t    command_q [$];
  pin_report_t pin_reports_q [$];
  pin_cmd_t    in_flight;

  int cmds_total;
  int cmds_sent;
  int reports_seen;
  int mismatch_count;
  int toggles;
  int input_reads;
  int mode_count [8];
  int status_count [4];
  int gap_left;
  int stall_left;
  int hold_left;
  int idle_cycles;
  bit send_quiet;
  bit rsp_quiet;

  function automatic pin_report_t update_pins(pin_cmd_t c);
    pin_report_t                 r;
    int                          idx;
    int                          i;
    logic [7:0]                  sel;
    logic [gpbc_pkg::TIME_W-1:0] elapsed;
    r   = '0;
    idx = -1;
    for (i = 0; i < NUM_PINS; i++) begin
      if (gpbc_pkg::PIN_TABLE[i] == c.pin) idx = i;
    end
    sel = (idx >= 0) ? 8'(1 << idx) : 8'h00;
    mode_count[c.mode]++;
    case (c.mode)
      gpbc_pkg::MODE_TICK: begin
        clock_ms = clock_ms + gpbc_pkg::TIME_W'(1);
        for (i = 0; i < NUM_PINS; i++) begin
          if (dir_bits[i] && blink_bits[i]) begin
            elapsed = clock_ms - toggle_ms[i];
            if (elapsed > gpbc_pkg::TIME_W'(period_ms[i])) begin
              level_bits[i] = ~level_bits[i];
              toggle_ms[i]  = clock_ms;
              toggles++;
            end
          end
        end
      end
      gpbc_pkg::MODE_DIR: begin
        if (c.value > VAL_HIGH) r.status = gpbc_pkg::ST_BAD_VALUE;
        else if (idx < 0) r.status = gpbc_pkg::ST_UNKNOWN;
        else if (c.value == VAL_HIGH) dir_bits = dir_bits | sel;
        else dir_bits = dir_bits & ~sel;
      end
      gpbc_pkg::MODE_LEVEL: begin
        if (idx < 0) r.status = gpbc_pkg::ST_UNKNOWN;
        else if ((dir_bits & sel) == 8'h00) r.status = gpbc_pkg::ST_WRONG_DIR;
        else if (c.value > VAL_HIGH) r.status = gpbc_pkg::ST_BAD_VALUE;
        else begin
          blink_bits = blink_bits & ~sel;
          if (c.value == VAL_HIGH) level_bits = level_bits | sel;
          else level_bits = level_bits & ~sel;
        end
      end
      gpbc_pkg::MODE_BLINK: begin
        if (idx < 0) r.status = gpbc_pkg::ST_UNKNOWN;
        else if ((dir_bits & sel) == 8'h00) r.status = gpbc_pkg::ST_WRONG_DIR;
        else if (c.value == VAL_LOW || c.value > gpbc_pkg::MAX_BLINK_HZ)
          r.status = gpbc_pkg::ST_BAD_VALUE;
        else begin
          blink_bits     = blink_bits | sel;
          period_ms[idx] = gpbc_pkg::PERIOD_W'(32'(gpbc_pkg::MS_PER_S) / 32'(c.value));
        end
      end
      gpbc_pkg::MODE_READ: begin
        if (idx < 0) r.status = gpbc_pkg::ST_UNKNOWN;
        else if ((dir_bits & sel) != 8'h00) r.status = gpbc_pkg::ST_WRONG_DIR;
        else begin
          r.rd = |(c.sampled & sel);
          input_reads++;
        end
      end
      default: r.status = gpbc_pkg::ST_BAD_VALUE;
    endcase
    status_count[r.status]++;
    r.driven = level_bits & dir_bits;
    r.oe     = dir_bits;
    return r;
  endfunction

  function automatic pin_cmd_t random_command();
    pin_cmd_t c;
    int       pick;
    c.sampled = 8'($urandom);
    c.value   = 16'($urandom);
    c.pin     = ($urandom_range(0, 4) != 0)
                ? gpbc_pkg::PIN_TABLE[$urandom_range(0, NUM_PINS - 1)]
                : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.mode = gpbc_pkg::MODE_TICK;
    end else if (pick < 52) begin
      c.mode = gpbc_pkg::MODE_DIR;
      if ($urandom_range(0, 6) != 0) c.value = 16'($urandom_range(0, 1));
    end else if (pick < 64) begin
      c.mode = gpbc_pkg::MODE_LEVEL;
      if ($urandom_range(0, 6) != 0) c.value = 16'($urandom_range(0, 1));
    end else if (pick < 82) begin
      c.mode = gpbc_pkg::MODE_BLINK;
      pick   = $urandom_range(0, 19);
      if (pick < 14) c.value = 16'($urandom_range(334, 1000));
      else if (pick < 17) c.value = 16'($urandom_range(1, 1000));
      else if (pick == 17) c.value = 16'($urandom_range(1001, 65535));
      else if (pick == 18) c.value = VAL_LOW;
    end else if (pick < 94) begin
      c.mode = gpbc_pkg::MODE_READ;
    end else begin
      c.mode = (pick < 96) ? MODE_SPARE0 : (pick < 98) ? MODE_SPARE1 : MODE_SPARE2;
    end
    return c;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Command driver: predicts each beat as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ch.ready) begin
        pin_reports_q.push_back(update_pins(in_flight));
        cmds_sent++;
        if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
      end
      if (cmd_valid && !cmd_ch.ready) begin
        cmd_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (command_q.size() == 0 ||
                   (cmds_sent == DRAIN_AT && pin_reports_q.size() != 0)) begin
        cmd_valid <= 1'b0;
      end else begin
        in_flight = command_q.pop_front();
        cmd_mode    <= in_flight.mode;
        cmd_pin     <= in_flight.pin;
        cmd_value   <= in_flight.value;
        cmd_sampled <= in_flight.sampled;
        cmd_valid   <= 1'b1;
        gap_left = send_quiet ? 0 : $urandom_range(0, 5);
      end
    end
  end

  // Response monitor with random stalls and one long hold-off.
  always @(posedge clk) begin
    pin_report_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        if (pin_reports_q.size() == 0) begin
          $display("%0t: unexpected beat, status %0h", $time, rsp_ch.status);
          mismatch_count++;
        end else begin
          want = pin_reports_q.pop_front();
          check_field("status", 8'(want.status), 8'(rsp_ch.status));
          check_field("read_level", 8'(want.rd), 8'(rsp_ch.read_level));
          check_field("driven_levels", want.driven, rsp_ch.driven_levels);
          check_field("output_enables", want.oe, rsp_ch.output_enables);
        end
        reports_seen++;
        stall_left = rsp_quiet ? 0 : $urandom_range(0, 5);
        if (reports_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        if ($urandom_range(0, 39) == 0) rsp_quiet = ~rsp_quiet;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int i;
    dir_bits   = '1;
    blink_bits = '0;
    level_bits = '0;
    clock_ms   = '0;
    for (i = 0; i < NUM_PINS; i++) begin
      period_ms[i] = '0;
      toggle_ms[i] = '0;
    end

    // Directed opening: direction rules, value limits, unknown pins, blink, latch, ticks and spare modes.
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_READ,  8'd21,  16'd0,    8'hFF});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_DIR,   8'd21,  VAL_LOW,  8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_READ,  8'd21,  16'hFFFF, 8'h01});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_READ,  8'd21,  16'd0,    8'hFE});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_LEVEL, 8'd21,  VAL_HIGH, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_BLINK, 8'd21,  16'd500,  8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_DIR,   8'd0,   16'd2,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_DIR,   8'd255, VAL_HIGH, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_LEVEL, 8'd3,   VAL_HIGH, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_LEVEL, 8'd2,   16'd2,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_LEVEL, 8'd2,   VAL_HIGH, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_BLINK, 8'd19,  16'd0,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_BLINK, 8'd19,  16'd1001, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_BLINK, 8'd19,  16'd1000, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_BLINK, 8'd18,  16'd1,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_BLINK, 8'd4,   16'hFFFF, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_TICK,  8'd255, 16'hFFFF, 8'hFF});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_TICK,  8'd0,   16'd0,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_DIR,   8'd19,  VAL_LOW,  8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_TICK,  8'd19,  16'd0,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_TICK,  8'd19,  16'd0,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_DIR,   8'd19,  VAL_HIGH, 8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_TICK,  8'd2,   16'd0,    8'h00});
    command_q.push_back(pin_cmd_t'{gpbc_pkg::MODE_LEVEL, 8'd19,  VAL_LOW,  8'h00});
    command_q.push_back(pin_cmd_t'{MODE_SPARE0,          8'd21,  VAL_HIGH, 8'h00});
    command_q.push_back(pin_cmd_t'{MODE_SPARE1,          8'd5,   VAL_LOW,  8'h00});
    command_q.push_back(pin_cmd_t'{MODE_SPARE2,          8'd16,  16'd7,    8'h00});
    for (i = 0; i < RANDOM_CMDS; i++) command_q.push_back(random_command());
    cmds_total = command_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (cmds_sent < cmds_total || pin_reports_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d ticks, %0d direction, %0d level, %0d blink, %0d read.",
             cmds_total, mode_count[gpbc_pkg::MODE_TICK], mode_count[gpbc_pkg::MODE_DIR],
             mode_count[gpbc_pkg::MODE_LEVEL], mode_count[gpbc_pkg::MODE_BLINK],
             mode_count[gpbc_pkg::MODE_READ]);
    $display("Saw %0d blink toggles, %0d input reads, %0d ok, %0d unknown, %0d wrong dir, %0d bad.",
             toggles, input_reads, status_count[gpbc_pkg::ST_OK],
             status_count[gpbc_pkg::ST_UNKNOWN], status_count[gpbc_pkg::ST_WRONG_DIR],
             status_count[gpbc_pkg::ST_BAD_VALUE]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
